// ===== design/aik_pkg.sv =====
// Shared constants, CORDIC arctangent table and helpers for the arm IK pipeline.
// No dependencies; imported by arm_inverse_kinematics, aik_vec_angle and the bench.
`default_nettype none
package aik_pkg;

    localparam int LINK_WIDTH      = 15;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LINK1 = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LINK2 = 1'd1;
    localparam logic [LINK_WIDTH-1:0] LINK_RESET = 15'd3200;

    localparam int D_WIDTH    = 31;
    localparam int LSUM_WIDTH = 31;

    localparam int VEC_WIDTH     = 64;
    localparam int NORM_STEPS    = 7;
    localparam int NORM_TARGET   = 58;
    localparam int CORDIC_STEPS  = 30;
    localparam int VEC_LATENCY   = 1 + NORM_STEPS + CORDIC_STEPS;

    localparam int R_SQRT_IN     = 64;
    localparam int S_SQRT_IN     = 62;
    localparam int R_SQRT_STAGES = R_SQRT_IN / 2;
    localparam int S_SQRT_STAGES = S_SQRT_IN / 2;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [33:0] TWO_PI_Q29 = 34'sd3373259426;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic int norm_shift(input int j);
        int s;
        case (j)
            0: s = 32;
            1: s = 16;
            2: s = 8;
            3: s = 4;
            4: s = 2;
            default: s = 1;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== design/aik_in_if.sv =====
// Input stream interface: wrist target and solution index per beat.
// Standalone; used by the top level.
`default_nettype none
interface aik_in_if #(
    parameter int POSITION_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] position_x;
    logic signed [POSITION_WIDTH-1:0] position_y;
    logic signed [POSITION_WIDTH-1:0] position_z;
    logic [1:0]                       solution_index;

    modport source (output valid, position_x, position_y, position_z, solution_index,
                    input ready);
    modport sink   (input valid, position_x, position_y, position_z, solution_index,
                    output ready);
endinterface
`default_nettype wire

// ===== design/aik_out_if.sv =====
// Output stream interface: three joint angles and the reach flag per beat.
// Standalone; used by the top level.
`default_nettype none
interface aik_out_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] theta_base;
    logic signed [ANGLE_WIDTH-1:0] theta_shoulder;
    logic signed [ANGLE_WIDTH-1:0] theta_elbow;
    logic                          reachable;

    modport source (output valid, theta_base, theta_shoulder, theta_elbow, reachable,
                    input ready);
    modport sink   (input valid, theta_base, theta_shoulder, theta_elbow, reachable,
                    output ready);
endinterface
`default_nettype wire

// ===== design/arm_inverse_kinematics.sv =====
// Three-joint arm inverse kinematics: squares, two root chains, four CORDIC chains.
// One beat per cycle sustained while the output is not stalled by o_out.ready, carried
// by the fixed-depth root and CORDIC cell rows. An output register parts the sides.
// Reset clears all valid bits and loads both link lengths with 3200.
// Depends on aik_pkg, aik_in_if, aik_out_if, aik_delay, aik_isqrt, aik_vec_angle.
`default_nettype none
module arm_inverse_kinematics #(
    parameter int POSITION_WIDTH      = 16,
    parameter int ANGLE_FRACTION_BITS = 13
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [aik_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [aik_pkg::LINK_WIDTH-1:0]       i_cfg_data,
    aik_in_if.sink                                    i_in,
    aik_out_if.source                                 o_out
);
    import aik_pkg::*;

    localparam int PW        = POSITION_WIDTH;
    localparam int AW        = ANGLE_FRACTION_BITS + 3;
    localparam int SCALE     = 32 - PW;
    localparam int SQW       = 2 * PW;
    localparam int NMW       = (SQW > LSUM_WIDTH) ? SQW : LSUM_WIDTH;
    localparam int RAD_SHIFT = 61 - ANGLE_FRACTION_BITS;

    localparam int ST_RSQ = 3;
    localparam int ST_NM  = 4;
    localparam int ST_R   = ST_RSQ + R_SQRT_STAGES;
    localparam int ST_DIF = 6;
    localparam int ST_S   = ST_DIF + S_SQRT_STAGES;
    localparam int ST_CS  = ST_S + 1;
    localparam int ST_K   = ST_CS + 2;
    localparam int ST_ARM = ST_K + VEC_LATENCY;
    localparam int NST    = ST_ARM + 2;

    localparam logic signed [63:0] MINUS_PI_PROD = -64'sd2147483648 * 64'(TWO_PI_Q29);
    localparam logic [AW-1:0]      MINUS_PI      = AW'(MINUS_PI_PROD >>> RAD_SHIFT);

    // configuration and derived link terms
    logic [LINK_WIDTH-1:0] r_link1;
    logic [LINK_WIDTH-1:0] r_link2;
    logic [LSUM_WIDTH-1:0] r_lsum;
    logic [D_WIDTH-1:0]    r_d;
    logic [45:0]           r_p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link1 <= LINK_RESET;
            r_link2 <= LINK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINK1: r_link1 <= i_cfg_data;
                CFG_LINK2: r_link2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lsum <= (LSUM_WIDTH'(r_link1) * LSUM_WIDTH'(r_link1))
                + (LSUM_WIDTH'(r_link2) * LSUM_WIDTH'(r_link2));
        r_d    <= (D_WIDTH'(r_link1) * D_WIDTH'(r_link2)) << 1;
        r_p1   <= 46'(r_link1) * 46'(r_d);
    end

    // flow control
    logic           w_en;
    logic [NST:1]   r_valid;
    logic           r_out_valid;

    assign w_en       = !r_valid[NST] || !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NST-1:1], i_in.valid};
        end
    end

    // stage 1 to 6: squares, reach test, root operands
    logic signed [PW-1:0]  r_x, r_y, r_z;
    logic [1:0]            r_sel;
    logic [SQW-1:0]        r_x2, r_y2, r_z2, r_sq, r_rxy;
    logic [NMW-1:0]        w_sq_ext, w_lsum_ext, w_nmag;
    logic                  w_neg;
    logic                  r_neg, r_reach;
    logic [D_WIDTH-1:0]    r_nmag;
    logic [S_SQRT_IN-1:0]  r_dsq, r_nsq, r_diff;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x   <= i_in.position_x;
            r_y   <= i_in.position_y;
            r_z   <= i_in.position_z;
            r_sel <= i_in.solution_index;
            r_x2  <= $unsigned(SQW'(r_x) * SQW'(r_x));
            r_y2  <= $unsigned(SQW'(r_y) * SQW'(r_y));
            r_z2  <= $unsigned(SQW'(r_z) * SQW'(r_z));
            r_sq  <= r_x2 + r_y2 + r_z2;
            r_rxy <= r_x2 + r_y2;
        end
    end

    assign w_sq_ext   = NMW'(r_sq);
    assign w_lsum_ext = NMW'(r_lsum);
    assign w_neg      = w_sq_ext < w_lsum_ext;
    assign w_nmag     = w_neg ? (w_lsum_ext - w_sq_ext) : (w_sq_ext - w_lsum_ext);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg   <= w_neg;
            r_reach <= w_nmag <= NMW'(r_d);
            r_nmag  <= w_nmag[D_WIDTH-1:0];
            r_dsq   <= S_SQRT_IN'(r_d) * S_SQRT_IN'(r_d);
            r_nsq   <= r_reach ? (S_SQRT_IN'(r_nmag) * S_SQRT_IN'(r_nmag)) : '0;
            r_diff  <= r_dsq - r_nsq;
        end
    end

    // root chains
    logic [R_SQRT_STAGES-1:0] w_r;
    logic [S_SQRT_STAGES-1:0] w_s;

    aik_isqrt #(.IN_WIDTH(R_SQRT_IN)) u_r_sqrt (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (R_SQRT_IN'(r_rxy) << (2 * SCALE)),
        .o_root  (w_r)
    );

    aik_isqrt #(.IN_WIDTH(S_SQRT_IN)) u_s_sqrt (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (r_diff),
        .o_root  (w_s)
    );

    // side data alignment
    logic [D_WIDTH+1:0]       w_nm_s;
    logic [1:0]               w_sel_s, w_sel_k;
    logic                     w_flip_a;
    logic [PW-1:0]            w_z_k;
    logic [R_SQRT_STAGES-1:0] w_r_k;
    logic [1:0]               w_nr_a;

    aik_delay #(.WIDTH(D_WIDTH + 2), .DEPTH(ST_S - ST_NM)) u_dly_nm (
        .i_clk (i_clk), .i_en (w_en),
        .i_data ({r_neg, r_reach, r_nmag}), .o_data (w_nm_s)
    );
    aik_delay #(.WIDTH(2), .DEPTH(ST_S - 1)) u_dly_sel_s (
        .i_clk (i_clk), .i_en (w_en), .i_data (r_sel), .o_data (w_sel_s)
    );
    aik_delay #(.WIDTH(2), .DEPTH(ST_K - 1 - ST_S)) u_dly_sel_k (
        .i_clk (i_clk), .i_en (w_en), .i_data (w_sel_s), .o_data (w_sel_k)
    );
    aik_delay #(.WIDTH(1), .DEPTH(ST_ARM - ST_K + 1)) u_dly_flip (
        .i_clk (i_clk), .i_en (w_en), .i_data (w_sel_k[1]), .o_data (w_flip_a)
    );
    aik_delay #(.WIDTH(PW), .DEPTH(ST_K - 2)) u_dly_z (
        .i_clk (i_clk), .i_en (w_en), .i_data (r_z), .o_data (w_z_k)
    );
    aik_delay #(.WIDTH(R_SQRT_STAGES), .DEPTH(ST_K - 1 - ST_R)) u_dly_r (
        .i_clk (i_clk), .i_en (w_en), .i_data (w_r), .o_data (w_r_k)
    );
    aik_delay #(.WIDTH(2), .DEPTH(ST_ARM - ST_S)) u_dly_nr (
        .i_clk (i_clk), .i_en (w_en),
        .i_data (w_nm_s[D_WIDTH+1:D_WIDTH]), .o_data (w_nr_a)
    );

    // elbow cosine/sine, k terms, reach vector
    logic                      w_neg_s, w_reach_s;
    logic [D_WIDTH-1:0]        w_nmag_s;
    logic signed [31:0]        r_c, r_sgns;
    logic signed [46:0]        r_p2, r_k2;
    logic signed [47:0]        r_k1, r_k2b;
    logic signed [32:0]        r_rr, r_hh;
    logic                      w_zero;

    assign {w_neg_s, w_reach_s, w_nmag_s} = w_nm_s;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_reach_s) begin
                r_c    <= w_neg_s ? -$signed(32'(w_nmag_s)) : $signed(32'(w_nmag_s));
                r_sgns <= w_sel_s[0] ? -$signed(32'(w_s)) : $signed(32'(w_s));
            end else begin
                r_c    <= w_neg_s ? -$signed(32'(r_d)) : $signed(32'(r_d));
                r_sgns <= '0;
            end
            r_p2  <= 47'(r_c) * $signed(47'(r_link2));
            r_k2  <= 47'(r_sgns) * $signed(47'(r_link2));
            r_k1  <= $signed(48'(r_p1)) + 48'(r_p2);
            r_k2b <= 48'(r_k2);
            r_rr  <= w_sel_k[1] ? -$signed(33'(w_r_k)) : $signed(33'(w_r_k));
            r_hh  <= -(33'($signed(w_z_k)) <<< SCALE);
        end
    end

    assign w_zero = ((r_rr == 0) && (r_hh == 0)) || ((r_k1 == 0) && (r_k2b == 0));

    // angle chains
    logic [31:0] w_base_v, w_elbow_v, w_arm_a, w_arm_b, w_base_a, w_elbow_a;
    logic        w_zero_a;

    aik_vec_angle #(.IN_WIDTH(PW)) u_vec_base (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_x), .i_y (r_y), .o_angle (w_base_v)
    );
    aik_vec_angle #(.IN_WIDTH(32)) u_vec_elbow (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_c), .i_y (r_sgns), .o_angle (w_elbow_v)
    );
    aik_vec_angle #(.IN_WIDTH(33)) u_vec_reach (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_rr), .i_y (r_hh), .o_angle (w_arm_a)
    );
    aik_vec_angle #(.IN_WIDTH(48)) u_vec_k (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_k1), .i_y (r_k2b), .o_angle (w_arm_b)
    );

    aik_delay #(.WIDTH(32), .DEPTH(ST_ARM - 1 - VEC_LATENCY)) u_dly_base (
        .i_clk (i_clk), .i_en (w_en), .i_data (w_base_v), .o_data (w_base_a)
    );
    aik_delay #(.WIDTH(32), .DEPTH(ST_ARM - ST_CS - VEC_LATENCY)) u_dly_elbow (
        .i_clk (i_clk), .i_en (w_en), .i_data (w_elbow_v), .o_data (w_elbow_a)
    );
    aik_delay #(.WIDTH(1), .DEPTH(VEC_LATENCY)) u_dly_zero (
        .i_clk (i_clk), .i_en (w_en), .i_data (w_zero), .o_data (w_zero_a)
    );

    // final angle sums and scaling to radians
    logic [31:0]        r_tb, r_ta, r_te;
    logic               r_reach1, r_reach2;
    logic signed [63:0] r_mb, r_ma, r_me;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tb     <= w_base_a + (w_flip_a ? HALF_TURN : 32'h0);
            r_ta     <= w_zero_a ? QUARTER_TURN : (w_arm_a - w_arm_b + QUARTER_TURN);
            r_te     <= w_nr_a[0] ? w_elbow_a : (w_nr_a[1] ? HALF_TURN : 32'h0);
            r_reach1 <= w_nr_a[0];
            r_mb     <= 64'($signed(r_tb)) * 64'(TWO_PI_Q29);
            r_ma     <= 64'($signed(r_ta)) * 64'(TWO_PI_Q29);
            r_me     <= 64'($signed(r_te)) * 64'(TWO_PI_Q29);
            r_reach2 <= r_reach1;
        end
    end

    // output register
    logic [AW-1:0] r_out_base, r_out_shoulder, r_out_elbow;
    logic          r_out_reach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && r_valid[NST]) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_valid[NST]) begin
            r_out_base     <= AW'(r_mb >>> RAD_SHIFT);
            r_out_shoulder <= AW'(r_ma >>> RAD_SHIFT);
            r_out_elbow    <= AW'(r_me >>> RAD_SHIFT);
            r_out_reach    <= r_reach2;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.theta_base     = r_out_base;
    assign o_out.theta_shoulder = r_out_shoulder;
    assign o_out.theta_elbow    = r_out_elbow;
    assign o_out.reachable      = r_out_reach;

    // out-of-reach beats carry a straight or fully folded elbow
    a_unreach_elbow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_reach |-> (r_out_elbow == '0 || r_out_elbow == MINUS_PI))
        else $error("unreachable beat with bent elbow");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[NST] && r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while pipeline is blocked");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_en && r_valid[NST]))
        else $error("output valid without a finished beat");

endmodule
`default_nettype wire

// ===== design/aik_delay.sv =====
// Enable-gated delay line that keeps side data aligned with the pipeline.
// No dependencies.
`default_nettype none
module aik_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_data,
    output logic      [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_tap [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];
endmodule
`default_nettype wire

// ===== design/aik_isqrt.sv =====
// Pipelined integer square root, one root bit per cell, floor result.
// Depends on nothing beyond its parameter.
`default_nettype none
module aik_isqrt #(
    parameter int IN_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [IN_WIDTH-1:0]   i_value,
    output logic      [IN_WIDTH/2-1:0] o_root
);
    localparam int OW = IN_WIDTH / 2;
    localparam int RW = IN_WIDTH + 1;

    logic [RW-1:0] w_rem [0:OW-1];
    logic [RW-1:0] w_res [0:OW-1];
    logic [RW-1:0] r_rem [1:OW];
    logic [RW-1:0] r_res [1:OW];

    for (genvar k = 0; k < OW; k++) begin : g_cell
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (OW - 1 - k));
        logic [RW-1:0] w_try;

        if (k == 0) begin : g_first
            assign w_rem[k] = RW'(i_value);
            assign w_res[k] = '0;
        end else begin : g_next
            assign w_rem[k] = r_rem[k];
            assign w_res[k] = r_res[k];
        end

        assign w_try = w_res[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem[k] >= w_try) begin
                    r_rem[k+1] <= w_rem[k] - w_try;
                    r_res[k+1] <= (w_res[k] >> 1) + BIT;
                end else begin
                    r_rem[k+1] <= w_rem[k];
                    r_res[k+1] <= w_res[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[OW][OW-1:0];
endmodule
`default_nettype wire

// ===== design/aik_vec_angle.sv =====
// Pipelined vector angle: special cases, normalizing shift cells, CORDIC cells.
// Depends on aik_pkg (table, step counts, turn constants).
`default_nettype none
module aik_vec_angle #(
    parameter int IN_WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic signed [IN_WIDTH-1:0] i_x,
    input  wire logic signed [IN_WIDTH-1:0] i_y,
    output logic [31:0]                     o_angle
);
    import aik_pkg::*;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] x;
        logic signed [VEC_WIDTH-1:0] y;
        logic [VEC_WIDTH-1:0]        m;
        logic [31:0]                 ang;
        logic                        fixed;
    } t_norm;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] x;
        logic signed [VEC_WIDTH-1:0] y;
        logic [31:0]                 ang;
        logic                        fixed;
    } t_rot;

    logic signed [VEC_WIDTH-1:0] w_x;
    logic signed [VEC_WIDTH-1:0] w_y;
    logic signed [VEC_WIDTH-1:0] w_ay;
    t_norm n_pre;
    t_norm r_norm [0:NORM_STEPS];
    t_rot  w_cin  [0:CORDIC_STEPS-1];
    t_rot  r_rot  [1:CORDIC_STEPS];

    assign w_x = VEC_WIDTH'(i_x);
    assign w_y = VEC_WIDTH'(i_y);

    always_comb begin
        n_pre.fixed = (w_y == 0) || (w_x == 0);
        if (w_y == 0) begin
            n_pre.ang = (w_x < 0) ? HALF_TURN : 32'h0;
        end else if (w_x == 0) begin
            n_pre.ang = (w_y > 0) ? QUARTER_TURN : (HALF_TURN + QUARTER_TURN);
        end else begin
            n_pre.ang = (w_x < 0) ? HALF_TURN : 32'h0;
        end
        n_pre.x = (w_x < 0) ? -w_x : w_x;
        n_pre.y = (w_x < 0) ? -w_y : w_y;
        w_ay    = (n_pre.y < 0) ? -n_pre.y : n_pre.y;
        n_pre.m = (n_pre.x > w_ay) ? $unsigned(n_pre.x) : $unsigned(w_ay);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm[0] <= n_pre;
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH  = norm_shift(j);
        localparam int LIM = (j == NORM_STEPS - 1) ? NORM_TARGET : NORM_TARGET - SH;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_norm[j+1].ang   <= r_norm[j].ang;
                r_norm[j+1].fixed <= r_norm[j].fixed;
                if (r_norm[j].m < (VEC_WIDTH'(1) << LIM)) begin
                    r_norm[j+1].x <= r_norm[j].x <<< SH;
                    r_norm[j+1].y <= r_norm[j].y <<< SH;
                    r_norm[j+1].m <= r_norm[j].m << SH;
                end else begin
                    r_norm[j+1].x <= r_norm[j].x;
                    r_norm[j+1].y <= r_norm[j].y;
                    r_norm[j+1].m <= r_norm[j].m;
                end
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic [31:0] ATAN = atan_entry(i);

        if (i == 0) begin : g_first
            assign w_cin[i].x     = r_norm[NORM_STEPS].x;
            assign w_cin[i].y     = r_norm[NORM_STEPS].y;
            assign w_cin[i].ang   = r_norm[NORM_STEPS].ang;
            assign w_cin[i].fixed = r_norm[NORM_STEPS].fixed;
        end else begin : g_next
            assign w_cin[i] = r_rot[i];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rot[i+1].fixed <= w_cin[i].fixed;
                if (w_cin[i].fixed) begin
                    r_rot[i+1].x   <= w_cin[i].x;
                    r_rot[i+1].y   <= w_cin[i].y;
                    r_rot[i+1].ang <= w_cin[i].ang;
                end else if (w_cin[i].y > 0) begin
                    r_rot[i+1].x   <= w_cin[i].x + (w_cin[i].y >>> i);
                    r_rot[i+1].y   <= w_cin[i].y - (w_cin[i].x >>> i);
                    r_rot[i+1].ang <= w_cin[i].ang + ATAN;
                end else begin
                    r_rot[i+1].x   <= w_cin[i].x - (w_cin[i].y >>> i);
                    r_rot[i+1].y   <= w_cin[i].y + (w_cin[i].x >>> i);
                    r_rot[i+1].ang <= w_cin[i].ang - ATAN;
                end
            end
        end
    end

    assign o_angle = r_rot[CORDIC_STEPS].ang;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for arm_inverse_kinematics: drives wrist targets, predicts joint angles.
// Depends on aik_pkg, aik_in_if, aik_out_if and the arm_inverse_kinematics top level.
`default_nettype none
module tb;
    import aik_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [1:0]         sel;
    } target_t;

    typedef struct packed {
        logic signed [15:0] base;
        logic signed [15:0] shoulder;
        logic signed [15:0] elbow;
        logic               reach;
    } joints_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY        = 80;

    logic [31:0] atan_rom [30] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [LINK_WIDTH-1:0]      i_cfg_data;

    aik_in_if  #(.POSITION_WIDTH(16)) in_if ();
    aik_out_if #(.ANGLE_WIDTH(16))    out_if ();

    arm_inverse_kinematics u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    longint  upper_arm, forearm;
    target_t targets_pending[$];
    joints_t joints_expected[$];
    int      errors, results_seen, targets_sent, idle_cycles, reach_seen, miss_seen;
    bit      timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] bin_angle(longint x, longint y);
        logic [31:0] a;
        longint m, ay, t;
        a = 0;
        if (y == 0) return (x < 0) ? HALF_TURN : 32'd0;
        if (x == 0) return (y > 0) ? QUARTER_TURN : HALF_TURN + QUARTER_TURN;
        if (x < 0) begin
            x = -x;
            y = -y;
            a = HALF_TURN;
        end
        ay = (y < 0) ? -y : y;
        m = (x > ay) ? x : ay;
        while (m < (64'sd1 <<< 58)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < 30; i++) begin
            if (y > 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                a = a + atan_rom[i];
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                a = a - atan_rom[i];
            end
        end
        return a;
    endfunction

    function automatic logic [15:0] to_q13(logic [31:0] ba);
        int     si;
        longint p;
        si = ba;
        p = longint'(si) * 64'sd3373259426;
        p = p >>> 48;
        return p[15:0];
    endfunction

    function automatic joints_t solve_joints(target_t t);
        joints_t j;
        longint x, y, z, d, c, s, sgn_s, k1, k2, rr, hh, sq, lsum, nmag;
        logic [63:0] r;
        logic [31:0] base, elbow, arm;
        logic neg, reach;
        x = t.x;
        y = t.y;
        z = t.z;
        d = 2 * upper_arm * forearm;
        base = bin_angle(x, y) + (t.sel[1] ? HALF_TURN : 32'd0);
        sq = x * x + y * y + z * z;
        lsum = upper_arm * upper_arm + forearm * forearm;
        neg = sq < lsum;
        nmag = neg ? lsum - sq : sq - lsum;
        reach = nmag <= d;
        if (reach) begin
            c = neg ? -nmag : nmag;
            s = longint'(int_sqrt(64'(d * d - nmag * nmag)));
            sgn_s = t.sel[0] ? -s : s;
            elbow = bin_angle(c, sgn_s);
        end else begin
            c = neg ? -d : d;
            sgn_s = 0;
            elbow = neg ? HALF_TURN : 32'd0;
        end
        k1 = upper_arm * d + forearm * c;
        k2 = forearm * sgn_s;
        r = int_sqrt(64'(x * x + y * y) << 32);
        rr = t.sel[1] ? -longint'(r) : longint'(r);
        hh = -z * 65536;
        if ((rr == 0 && hh == 0) || (k1 == 0 && k2 == 0)) arm = 0;
        else arm = bin_angle(rr, hh) - bin_angle(k1, k2);
        j.base = to_q13(base);
        j.shoulder = to_q13(arm + QUARTER_TURN);
        j.elbow = to_q13(elbow);
        j.reach = reach;
        return j;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // sender
    int send_gap;
    always @(posedge i_clk) begin
        logic    busy;
        int      gap;
        target_t t;
        busy = in_if.valid;
        gap = send_gap;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                t = {in_if.position_x, in_if.position_y, in_if.position_z, in_if.solution_index};
                joints_expected.push_back(solve_joints(t));
                targets_sent++;
                busy = 1'b0;
                gap = pick_gap();
            end
            if (!busy) begin
                if (gap > 0) begin
                    gap = gap - 1;
                    in_if.valid <= 1'b0;
                end else if (targets_pending.size() > 0) begin
                    t = targets_pending.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.position_x <= t.x;
                    in_if.position_y <= t.y;
                    in_if.position_z <= t.z;
                    in_if.solution_index <= t.sel;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            send_gap <= gap;
        end
    end

    // receiver and checker
    int sink_gap, long_stall;
    bit stall_done;
    always @(posedge i_clk) begin
        joints_t e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            sink_gap <= 0;
            long_stall <= 0;
        end else begin
            if (in_if.valid && in_if.ready || out_if.valid && out_if.ready) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (joints_expected.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = joints_expected.pop_front();
                    if (e.reach) reach_seen++;
                    else miss_seen++;
                    if (out_if.theta_base !== e.base) begin
                        $error("theta_base exp %0d got %0d", e.base, out_if.theta_base);
                        errors++;
                    end
                    if (out_if.theta_shoulder !== e.shoulder) begin
                        $error("theta_shoulder exp %0d got %0d", e.shoulder,
                               out_if.theta_shoulder);
                        errors++;
                    end
                    if (out_if.theta_elbow !== e.elbow) begin
                        $error("theta_elbow exp %0d got %0d", e.elbow, out_if.theta_elbow);
                        errors++;
                    end
                    if (out_if.reachable !== e.reach) begin
                        $error("reachable exp %0d got %0d", e.reach, out_if.reachable);
                        errors++;
                    end
                end
            end
            // one long hold-off to back the pipe up into the input
            if (!stall_done && results_seen == 200) begin
                stall_done <= 1'b1;
                long_stall <= 400;
                out_if.ready <= 1'b0;
            end else if (long_stall > 0) begin
                long_stall <= long_stall - 1;
                out_if.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if ((results_seen / 150) % 2 == 1) sink_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic add_target(int x, int y, int z, int sel);
        target_t t;
        t.x = 16'(x);
        t.y = 16'(y);
        t.z = 16'(z);
        t.sel = 2'(sel);
        targets_pending.push_back(t);
    endtask

    task automatic drain();
        while (targets_pending.size() > 0 || in_if.valid || joints_expected.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_link(logic [CFG_INDEX_WIDTH-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= LINK_WIDTH'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LINK1) upper_arm = val;
        else forearm = val;
    endtask

    function automatic int rand_coord(int lim);
        if (lim > 32767) lim = 32767;
        if ($urandom_range(9) < 3) return $signed($urandom_range(65535) - 32768);
        return $urandom_range(2 * lim) - lim;
    endfunction

    task automatic add_random(int n);
        int lim;
        for (int i = 0; i < n; i++) begin
            lim = int'((upper_arm + forearm) * 3 / 5 + 1);
            add_target(rand_coord(lim), rand_coord(lim), rand_coord(lim), $urandom_range(3));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LINK1;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.position_x = '0;
        in_if.position_y = '0;
        in_if.position_z = '0;
        in_if.solution_index = '0;
        out_if.ready = 1'b0;
        upper_arm = 3200;
        forearm = 3200;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < 4; s++) begin
            add_target(0, 0, 0, s);
            add_target(-32768, 0, 0, s);
            add_target(32767, 32767, 32767, s);
            add_target(-32768, -32768, -32768, s);
        end
        add_target(6400, 0, 0, 0);          // fully stretched
        add_target(0, 0, -6400, 1);
        add_target(3200, 3200, 0, 1);
        add_target(0, 4525, 0, 2);          // right angle at the elbow
        add_target(-100, 0, 0, 3);          // folded back
        add_target(0, -32768, 32767, 2);
        add_target(0, 0, 9000, 0);
        add_target(1, 0, 0, 1);
        add_target(0, 0, 0, 3);
        drain();

        add_random(1000);
        drain();
        write_link(CFG_LINK1, 1);
        write_link(CFG_LINK2, 1);
        add_target(2, 0, 0, 0);
        add_target(0, 0, 0, 1);
        add_random(100);
        drain();
        write_link(CFG_LINK1, 32767);
        write_link(CFG_LINK2, 32767);
        add_random(150);
        drain();
        write_link(CFG_LINK1, 1);
        add_target(32766, 0, 0, 0);
        add_target(0, 32768 - 2, 0, 3);
        add_random(100);
        drain();
        write_link(CFG_LINK1, 0);           // degenerate link
        write_link(CFG_LINK2, 500);
        add_target(500, 0, 0, 0);
        add_target(0, 0, 0, 1);
        add_random(30);
        drain();
        for (int p = 0; p < 4; p++) begin
            write_link(CFG_LINK1, $urandom_range(1, 32767));
            write_link(CFG_LINK2, $urandom_range(1, 32767));
            add_random(50);
            drain();
        end
        write_link(CFG_LINK1, 3200);
        write_link(CFG_LINK2, 3200);
        add_random(50);
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("tb: %0d targets, %0d results (%0d in reach, %0d out of reach)",
                 targets_sent, results_seen, reach_seen, miss_seen);
        $display("tb: link lengths swept over extremes, zero and random values");
        if (errors == 0 && joints_expected.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/aik_pkg.sv
design/aik_in_if.sv
design/aik_out_if.sv
design/aik_delay.sv
design/aik_isqrt.sv
design/aik_vec_angle.sv
design/arm_inverse_kinematics.sv
verif/tb.sv
